### rtl/owm_pkg.sv
// Package: types, codes and constants of the 1-Wire bus master.
package owm_pkg;

   localparam int unsigned BITS_PER_BYTE  = 8;
   localparam int unsigned LONG_WIDTH     = 12;
   localparam int unsigned SHORT_WIDTH    = 8;
   localparam int unsigned OPCODE_WIDTH   = 2;
   localparam int unsigned STATUS_WIDTH   = 2;
   localparam int unsigned CSR_IDX_WIDTH  = 3;
   localparam int unsigned CSR_DATA_WIDTH = 12;
   localparam int unsigned BIT_IDX_WIDTH  = $clog2(BITS_PER_BYTE);

   localparam logic [LONG_WIDTH-1:0] LOW_LEN_MAX      = 12'd4095;
   localparam logic [LONG_WIDTH-1:0] PRESENCE_MAX_LEN = 12'd600;
   localparam logic [LONG_WIDTH-1:0] ABSENCE_MIN_LEN  = 12'd680;

   localparam logic [LONG_WIDTH-1:0]  RESET_LOW_DEFAULT     = 12'd420;
   localparam logic [LONG_WIDTH-1:0]  PRESENCE_WIN_DEFAULT  = 12'd550;
   localparam logic [SHORT_WIDTH-1:0] ZERO_LOW_DEFAULT      = 8'd55;
   localparam logic [SHORT_WIDTH-1:0] SHORT_LOW_DEFAULT     = 8'd3;
   localparam logic [SHORT_WIDTH-1:0] ONE_RECOVERY_DEFAULT  = 8'd40;
   localparam logic [SHORT_WIDTH-1:0] READ_WINDOW_DEFAULT   = 8'd28;
   localparam logic [LONG_WIDTH-1:0]  PRESENCE_MIN_DEFAULT  = 12'd15;
   localparam logic [SHORT_WIDTH-1:0] READ_ONE_MAX_DEFAULT  = 8'd22;

   typedef enum logic [2:0] {
      PH_IDLE      = 3'd0,
      PH_RESET_LOW = 3'd1,
      PH_PRESENCE  = 3'd2,
      PH_WRITE_LOW = 3'd3,
      PH_WRITE_REL = 3'd4,
      PH_READ      = 3'd5
   } phase_type;

   typedef enum logic [OPCODE_WIDTH-1:0] {
      OP_NONE  = 2'd0,
      OP_RESET = 2'd1,
      OP_WRITE = 2'd2,
      OP_READ  = 2'd3
   } opcode_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      ST_OK        = 2'd0,
      ST_PRESENCE  = 2'd1,
      ST_ABSENCE   = 2'd2,
      ST_UNDECIDED = 2'd3
   } status_type;

   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      CSR_RESET_LOW    = 3'd0,
      CSR_PRESENCE_WIN = 3'd1,
      CSR_ZERO_LOW     = 3'd2,
      CSR_SHORT_LOW    = 3'd3,
      CSR_ONE_RECOVERY = 3'd4,
      CSR_READ_WINDOW  = 3'd5,
      CSR_PRESENCE_MIN = 3'd6,
      CSR_READ_ONE_MAX = 3'd7
   } csr_index_type;

endpackage

### rtl/owm_channels.sv
// Interfaces: command, result and register write channels of the bus master.
interface owm_req_if
   import owm_pkg::*;
();
   logic                    valid;
   logic                    ready;
   logic [OPCODE_WIDTH-1:0] opcode;
   logic [SHORT_WIDTH-1:0]  data_byte;
   logic                    line_level;

   modport source(output valid, opcode, data_byte, line_level, input ready);
   modport sink(input valid, opcode, data_byte, line_level, output ready);
endinterface

interface owm_rsp_if
   import owm_pkg::*;
();
   logic                    valid;
   logic                    ready;
   logic                    drive_low;
   logic                    busy_res;
   logic                    done_res;
   logic [STATUS_WIDTH-1:0] status;
   logic [SHORT_WIDTH-1:0]  read_value;

   modport source(output valid, drive_low, busy_res, done_res, status, read_value,
                  input ready);
   modport sink(input valid, drive_low, busy_res, done_res, status, read_value,
                output ready);
endinterface

interface owm_csr_if
   import owm_pkg::*;
();
   logic                      valid;
   logic                      ready;
   logic [CSR_IDX_WIDTH-1:0]  index;
   logic [CSR_DATA_WIDTH-1:0] data;

   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

### rtl/onewire_bus_master_core.sv
// 1-Wire bus master core: one tick per transaction, result registered.
// The result of a tick transaction is registered and presented in the cycle after it is accepted.
// Throughput: one tick per cycle; a held result stalls the next tick through req ready.
// Each tick is decoded in one pass of logic between the state and the result register.
// Reset (synchronous, active high) returns to idle, drops the result and reloads the
// register defaults; register writes are always accepted.
module onewire_bus_master_core
   import owm_pkg::*;
#(
   parameter int unsigned TICK_COUNT_WIDTH = 12
) (
   input logic       clock,
   input logic       reset,
   owm_req_if.sink   req_chan,
   owm_rsp_if.source rsp_chan,
   owm_csr_if.sink   csr_chan
);

   localparam int unsigned CMP_WIDTH =
      ((TICK_COUNT_WIDTH > LONG_WIDTH) ? TICK_COUNT_WIDTH : LONG_WIDTH) + 1;

   // configuration
   logic [LONG_WIDTH-1:0]  reset_low_ff;
   logic [LONG_WIDTH-1:0]  presence_win_ff;
   logic [SHORT_WIDTH-1:0] zero_low_ff;
   logic [SHORT_WIDTH-1:0] short_low_ff;
   logic [SHORT_WIDTH-1:0] one_recovery_ff;
   logic [SHORT_WIDTH-1:0] read_window_ff;
   logic [LONG_WIDTH-1:0]  presence_min_ff;
   logic [SHORT_WIDTH-1:0] read_one_max_ff;

   // state
   phase_type                   phase_ff, phase_in;
   logic [OPCODE_WIDTH-1:0]     op_ff, op_in;
   logic [TICK_COUNT_WIDTH-1:0] tick_ff, tick_in;
   logic [BIT_IDX_WIDTH-1:0]    bit_idx_ff, bit_idx_in;
   logic [SHORT_WIDTH-1:0]      shift_ff, shift_in;
   logic [LONG_WIDTH-1:0]       low_len_ff, low_len_in;
   logic                        low_seen_ff, low_seen_in;

   // result register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    drive_ff, drive_in;
   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [STATUS_WIDTH-1:0] status_ff, status_in;
   logic [SHORT_WIDTH-1:0]  value_ff, value_in;

   // tick decode
   logic                        req_accept;
   logic                        start;
   phase_type                   cur_phase;
   logic [OPCODE_WIDTH-1:0]     cur_op;
   logic [TICK_COUNT_WIDTH-1:0] cur_tick;
   logic [BIT_IDX_WIDTH-1:0]    cur_bit;
   logic [SHORT_WIDTH-1:0]      cur_shift;
   logic [LONG_WIDTH-1:0]       cur_low_len;
   logic                        cur_low_seen;
   logic [SHORT_WIDTH-1:0]      low_time;
   logic [SHORT_WIDTH-1:0]      slot_len;
   logic [LONG_WIDTH-1:0]       phase_len;
   logic [LONG_WIDTH-1:0]       phase_len1;
   logic [CMP_WIDTH-1:0]        tick_next;
   logic                        phase_end;
   logic [LONG_WIDTH-1:0]       samp_low_len;
   logic                        samp_low_seen;
   logic                        last_bit;
   logic                        read_bit;
   logic [SHORT_WIDTH-1:0]      read_shift;

   assign req_accept     = req_chan.valid && req_chan.ready;
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         reset_low_ff    <= RESET_LOW_DEFAULT;
         presence_win_ff <= PRESENCE_WIN_DEFAULT;
         zero_low_ff     <= ZERO_LOW_DEFAULT;
         short_low_ff    <= SHORT_LOW_DEFAULT;
         one_recovery_ff <= ONE_RECOVERY_DEFAULT;
         read_window_ff  <= READ_WINDOW_DEFAULT;
         presence_min_ff <= PRESENCE_MIN_DEFAULT;
         read_one_max_ff <= READ_ONE_MAX_DEFAULT;
      end else if (csr_chan.valid) begin
         unique case (csr_index_type'(csr_chan.index))
            CSR_RESET_LOW:    reset_low_ff    <= csr_chan.data;
            CSR_PRESENCE_WIN: presence_win_ff <= csr_chan.data;
            CSR_ZERO_LOW:     zero_low_ff     <= csr_chan.data[SHORT_WIDTH-1:0];
            CSR_SHORT_LOW:    short_low_ff    <= csr_chan.data[SHORT_WIDTH-1:0];
            CSR_ONE_RECOVERY: one_recovery_ff <= csr_chan.data[SHORT_WIDTH-1:0];
            CSR_READ_WINDOW:  read_window_ff  <= csr_chan.data[SHORT_WIDTH-1:0];
            CSR_PRESENCE_MIN: presence_min_ff <= csr_chan.data;
            CSR_READ_ONE_MAX: read_one_max_ff <= csr_chan.data[SHORT_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // command start: an idle master takes the opcode on this tick
   always_comb begin
      start        = (phase_ff == PH_IDLE) && (req_chan.opcode != OP_NONE);
      cur_phase    = phase_ff;
      cur_op       = op_ff;
      cur_tick     = tick_ff;
      cur_bit      = bit_idx_ff;
      cur_shift    = shift_ff;
      cur_low_len  = low_len_ff;
      cur_low_seen = low_seen_ff;
      if (start) begin
         cur_op       = req_chan.opcode;
         cur_tick     = '0;
         cur_bit      = '0;
         cur_low_len  = '0;
         cur_low_seen = 1'b0;
         unique case (opcode_type'(req_chan.opcode))
            OP_RESET: cur_phase = PH_RESET_LOW;
            OP_READ:  cur_phase = PH_READ;
            default:  cur_phase = PH_WRITE_LOW;
         endcase
         cur_shift = (req_chan.opcode == OP_WRITE) ? req_chan.data_byte : '0;
      end
   end

   // phase length, tick count and line sampling
   always_comb begin
      low_time = (short_low_ff == '0) ? SHORT_WIDTH'(1) : short_low_ff;
      slot_len = (read_window_ff > low_time) ? read_window_ff : low_time;
      unique case (cur_phase)
         PH_RESET_LOW: phase_len = reset_low_ff;
         PH_PRESENCE:  phase_len = presence_win_ff;
         PH_WRITE_LOW: phase_len = LONG_WIDTH'(cur_shift[0] ? short_low_ff : zero_low_ff);
         PH_WRITE_REL: phase_len = LONG_WIDTH'(one_recovery_ff);
         PH_READ:      phase_len = LONG_WIDTH'(slot_len);
         default:      phase_len = '0;
      endcase
      phase_len1 = (phase_len == '0) ? LONG_WIDTH'(1) : phase_len;
      tick_next  = CMP_WIDTH'(cur_tick) + CMP_WIDTH'(1);
      phase_end  = (cur_phase != PH_IDLE)
                   && ((tick_next >= CMP_WIDTH'(phase_len1)) || (&cur_tick));

      samp_low_len  = cur_low_len;
      samp_low_seen = cur_low_seen;
      if (!req_chan.line_level) begin
         samp_low_seen = 1'b1;
         if (cur_low_len < LOW_LEN_MAX) begin
            samp_low_len = cur_low_len + LONG_WIDTH'(1);
         end
      end

      last_bit   = (cur_bit == BIT_IDX_WIDTH'(BITS_PER_BYTE - 1));
      read_bit   = (samp_low_len <= LONG_WIDTH'(read_one_max_ff));
      read_shift = {read_bit, cur_shift[SHORT_WIDTH-1:1]};
   end

   // next state
   always_comb begin
      phase_in    = cur_phase;
      op_in       = cur_op;
      tick_in     = cur_tick;
      bit_idx_in  = cur_bit;
      shift_in    = cur_shift;
      low_len_in  = cur_low_len;
      low_seen_in = cur_low_seen;
      if (cur_phase != PH_IDLE) begin
         tick_in = phase_end ? '0 : (cur_tick + TICK_COUNT_WIDTH'(1));
      end
      unique case (cur_phase)
         PH_IDLE: ;
         PH_RESET_LOW: begin
            if (phase_end) begin
               phase_in    = PH_PRESENCE;
               low_len_in  = '0;
               low_seen_in = 1'b0;
            end
         end
         PH_PRESENCE: begin
            low_len_in  = samp_low_len;
            low_seen_in = samp_low_seen;
            if (phase_end) begin
               phase_in = PH_IDLE;
            end
         end
         PH_WRITE_LOW, PH_WRITE_REL, PH_READ: begin
            if (cur_phase == PH_READ) begin
               low_len_in  = samp_low_len;
               low_seen_in = samp_low_seen;
            end
            if (phase_end && (cur_phase == PH_WRITE_LOW) && cur_shift[0]) begin
               phase_in = PH_WRITE_REL;
            end else if (phase_end) begin
               shift_in = (cur_phase == PH_READ) ? read_shift
                                                 : (cur_shift >> 1);
               if (last_bit) begin
                  phase_in   = PH_IDLE;
                  bit_idx_in = '0;
               end else begin
                  bit_idx_in  = cur_bit + BIT_IDX_WIDTH'(1);
                  low_len_in  = '0;
                  low_seen_in = 1'b0;
                  phase_in    = (cur_op == OP_READ) ? PH_READ : PH_WRITE_LOW;
               end
            end
         end
         default: phase_in = PH_IDLE;
      endcase
   end

   // result of this tick
   always_comb begin
      drive_in  = 1'b0;
      busy_in   = (cur_phase != PH_IDLE);
      done_in   = 1'b0;
      status_in = ST_OK;
      value_in  = '0;
      unique case (cur_phase)
         PH_IDLE: ;
         PH_RESET_LOW: drive_in = 1'b1;
         PH_PRESENCE: begin
            if (phase_end) begin
               done_in = 1'b1;
               if (!samp_low_seen) begin
                  status_in = ST_ABSENCE;
               end else if ((samp_low_len > presence_min_ff)
                            && (samp_low_len < PRESENCE_MAX_LEN)) begin
                  status_in = ST_PRESENCE;
               end else if (samp_low_len > ABSENCE_MIN_LEN) begin
                  status_in = ST_ABSENCE;
               end else begin
                  status_in = ST_UNDECIDED;
               end
            end
         end
         PH_WRITE_LOW: begin
            drive_in = 1'b1;
            done_in  = phase_end && !cur_shift[0] && last_bit;
         end
         PH_WRITE_REL: done_in = phase_end && last_bit;
         PH_READ: begin
            drive_in = (CMP_WIDTH'(cur_tick) < CMP_WIDTH'(low_time));
            if (phase_end && last_bit) begin
               done_in  = 1'b1;
               value_in = read_shift;
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         op_ff        <= OP_NONE;
         tick_ff      <= '0;
         bit_idx_ff   <= '0;
         shift_ff     <= '0;
         low_len_ff   <= '0;
         low_seen_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) begin
            phase_ff    <= phase_in;
            op_ff       <= op_in;
            tick_ff     <= tick_in;
            bit_idx_ff  <= bit_idx_in;
            shift_ff    <= shift_in;
            low_len_ff  <= low_len_in;
            low_seen_ff <= low_seen_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         drive_ff  <= drive_in;
         busy_ff   <= busy_in;
         done_ff   <= done_in;
         status_ff <= status_in;
         value_ff  <= value_in;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.drive_low  = drive_ff;
   assign rsp_chan.busy_res   = busy_ff;
   assign rsp_chan.done_res   = done_ff;
   assign rsp_chan.status     = status_ff;
   assign rsp_chan.read_value = value_ff;

`ifndef ASSERT_OFF
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (phase_ff == PH_IDLE) && (req_chan.opcode != OP_NONE))
      |=> rsp_chan.busy_res)
      else $error("command accepted while idle did not report busy");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (req_accept && done_in) |=> (phase_ff == PH_IDLE))
      else $error("operation completed but master not idle");

   a_status_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (status_ff != ST_OK)) |-> done_ff)
      else $error("status reported outside a completing tick");

   a_bit_idx_phase: assert property (@(posedge clock) disable iff (reset)
      (bit_idx_ff != '0) |-> ((phase_ff == PH_WRITE_LOW) || (phase_ff == PH_WRITE_REL)
                              || (phase_ff == PH_READ)))
      else $error("bit index live outside a byte transaction");
`endif

endmodule

### tb/tb_onewire_bus_master_core.sv
// Self-checking testbench of the 1-Wire bus master core with its scoreboard class.
`timescale 1ns / 1ps

package owm_tb_pkg;
   import owm_pkg::*;

   localparam int unsigned TB_TICK_WIDTH = 12;
   localparam int unsigned TB_TICK_MAX   = (1 << TB_TICK_WIDTH) - 1;

   typedef struct packed {
      logic                   drive_low;
      logic                   busy;
      logic                   done;
      status_type             status;
      logic [SHORT_WIDTH-1:0] read_value;
   } tick_result_type;

   class owm_tick_scoreboard;
      logic [LONG_WIDTH-1:0]  reset_low;
      logic [LONG_WIDTH-1:0]  presence_win;
      logic [SHORT_WIDTH-1:0] zero_low;
      logic [SHORT_WIDTH-1:0] short_low;
      logic [SHORT_WIDTH-1:0] one_recovery;
      logic [SHORT_WIDTH-1:0] read_window;
      logic [LONG_WIDTH-1:0]  presence_min;
      logic [SHORT_WIDTH-1:0] read_one_max;

      phase_type                phase;
      opcode_type               op_kind;
      int unsigned              tick_count;
      logic [BIT_IDX_WIDTH-1:0] bit_index;
      logic [SHORT_WIDTH-1:0]   shift_byte;
      int unsigned              low_length;
      bit                       low_seen;

      tick_result_type expected_ticks[$];
      int unsigned     error_count;

      function new();
         reset_low    = RESET_LOW_DEFAULT;
         presence_win = PRESENCE_WIN_DEFAULT;
         zero_low     = ZERO_LOW_DEFAULT;
         short_low    = SHORT_LOW_DEFAULT;
         one_recovery = ONE_RECOVERY_DEFAULT;
         read_window  = READ_WINDOW_DEFAULT;
         presence_min = PRESENCE_MIN_DEFAULT;
         read_one_max = READ_ONE_MAX_DEFAULT;
         phase        = PH_IDLE;
         op_kind      = OP_NONE;
         tick_count   = 0;
         bit_index    = '0;
         shift_byte   = '0;
         low_length   = 0;
         low_seen     = 1'b0;
         error_count  = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [CSR_DATA_WIDTH-1:0] value);
         unique case (idx)
            CSR_RESET_LOW:    reset_low    = value;
            CSR_PRESENCE_WIN: presence_win = value;
            CSR_ZERO_LOW:     zero_low     = value[SHORT_WIDTH-1:0];
            CSR_SHORT_LOW:    short_low    = value[SHORT_WIDTH-1:0];
            CSR_ONE_RECOVERY: one_recovery = value[SHORT_WIDTH-1:0];
            CSR_READ_WINDOW:  read_window  = value[SHORT_WIDTH-1:0];
            CSR_PRESENCE_MIN: presence_min = value;
            CSR_READ_ONE_MAX: read_one_max = value[SHORT_WIDTH-1:0];
         endcase
      endfunction

      function bit idle();
         return phase == PH_IDLE;
      endfunction

      function int unsigned pending();
         return expected_ticks.size();
      endfunction

      // zero length counts as one tick
      function bit phase_done(int unsigned len);
         int unsigned next_count;
         next_count = tick_count + 1;
         if (next_count >= ((len == 0) ? 1 : len) || next_count > TB_TICK_MAX) begin
            tick_count = 0;
            return 1'b1;
         end
         tick_count = next_count;
         return 1'b0;
      endfunction

      function void sample_level(logic level);
         if (level == 1'b0) begin
            low_seen = 1'b1;
            if (low_length < LOW_LEN_MAX)
               low_length++;
         end
      endfunction

      function void start_slot();
         tick_count = 0;
         low_length = 0;
         low_seen   = 1'b0;
         phase      = (op_kind == OP_READ) ? PH_READ : PH_WRITE_LOW;
      endfunction

      function bit finish_bit();
         if (bit_index >= BITS_PER_BYTE - 1) begin
            phase     = PH_IDLE;
            bit_index = '0;
            return 1'b1;
         end
         bit_index++;
         start_slot();
         return 1'b0;
      endfunction

      function void note_tick(opcode_type op, logic [SHORT_WIDTH-1:0] data, logic level);
         tick_result_type res;
         int unsigned     low_time;
         int unsigned     slot_len;
         logic            bit_val;
         res        = '0;
         res.status = ST_OK;
         if (phase == PH_IDLE && op != OP_NONE) begin
            op_kind    = op;
            bit_index  = '0;
            tick_count = 0;
            low_length = 0;
            low_seen   = 1'b0;
            if (op == OP_RESET) begin
               phase = PH_RESET_LOW;
            end else begin
               shift_byte = (op == OP_WRITE) ? data : '0;
               start_slot();
            end
         end
         res.busy = (phase != PH_IDLE);
         unique case (phase)
            PH_RESET_LOW: begin
               res.drive_low = 1'b1;
               if (phase_done(reset_low)) begin
                  phase      = PH_PRESENCE;
                  low_length = 0;
                  low_seen   = 1'b0;
               end
            end
            PH_PRESENCE: begin
               sample_level(level);
               if (phase_done(presence_win)) begin
                  if (!low_seen)
                     res.status = ST_ABSENCE;
                  else if (low_length > presence_min && low_length < PRESENCE_MAX_LEN)
                     res.status = ST_PRESENCE;
                  else if (low_length > ABSENCE_MIN_LEN)
                     res.status = ST_ABSENCE;
                  else
                     res.status = ST_UNDECIDED;
                  res.done = 1'b1;
                  phase    = PH_IDLE;
               end
            end
            PH_WRITE_LOW: begin
               res.drive_low = 1'b1;
               if (!shift_byte[0]) begin
                  if (phase_done(zero_low)) begin
                     shift_byte = shift_byte >> 1;
                     res.done   = finish_bit();
                  end
               end else if (phase_done(short_low)) begin
                  phase = PH_WRITE_REL;
               end
            end
            PH_WRITE_REL: begin
               if (phase_done(one_recovery)) begin
                  shift_byte = shift_byte >> 1;
                  res.done   = finish_bit();
               end
            end
            PH_READ: begin
               low_time      = (short_low == 0) ? 1 : short_low;
               slot_len      = (read_window > low_time) ? read_window : low_time;
               res.drive_low = (tick_count < low_time);
               sample_level(level);
               if (phase_done(slot_len)) begin
                  bit_val    = (low_length <= read_one_max);
                  shift_byte = {bit_val, shift_byte[SHORT_WIDTH-1:1]};
                  if (finish_bit()) begin
                     res.done       = 1'b1;
                     res.read_value = shift_byte;
                  end
               end
            end
            default: phase = PH_IDLE;
         endcase
         expected_ticks.push_back(res);
      endfunction

      function void compare_field(string name, logic [7:0] exp_val, logic [7:0] got_val);
         if (got_val !== exp_val) begin
            $error("%s: expected %0d, actual %0d", name, exp_val, got_val);
            error_count++;
         end
      endfunction

      function void check_tick(logic drive_low, logic busy, logic done,
                               logic [STATUS_WIDTH-1:0] status,
                               logic [SHORT_WIDTH-1:0] read_value);
         tick_result_type exp;
         if (expected_ticks.size() == 0) begin
            $error("result transaction with no expected result pending");
            error_count++;
            return;
         end
         exp = expected_ticks.pop_front();
         compare_field("drive_low", 8'(exp.drive_low), 8'(drive_low));
         compare_field("busy_res", 8'(exp.busy), 8'(busy));
         compare_field("done_res", 8'(exp.done), 8'(done));
         compare_field("status", 8'(exp.status), 8'(status));
         compare_field("read_value", exp.read_value, read_value);
      endfunction
   endclass
endpackage

module tb_onewire_bus_master_core;
   import owm_pkg::*;
   import owm_tb_pkg::*;

   localparam int unsigned STALL_LIMIT = 2000;

   logic clock;
   logic reset;

   owm_req_if req_chan();
   owm_rsp_if rsp_chan();
   owm_csr_if csr_chan();

   onewire_bus_master_core #(
      .TICK_COUNT_WIDTH(TB_TICK_WIDTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan),
      .csr_chan(csr_chan)
   );

   owm_tick_scoreboard board = new();

   bit          gaps_on;
   bit          line_stuck;
   int unsigned line_run_max;
   int unsigned low_left;
   int unsigned idle_cycles;
   logic [CSR_DATA_WIDTH-1:0] reg_plan [8];

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // line model: random low pulses of up to line_run_max ticks
   function automatic logic next_level();
      if (line_stuck)
         return 1'b0;
      if (low_left != 0) begin
         low_left--;
         return 1'b0;
      end
      if (line_run_max != 0 && $urandom_range(0, 5) == 0) begin
         low_left = $urandom_range(0, line_run_max - 1);
         return 1'b0;
      end
      return 1'b1;
   endfunction

   task automatic send_tick(opcode_type op, logic [SHORT_WIDTH-1:0] data, logic level);
      if (gaps_on && $urandom_range(0, 9) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.opcode     <= op;
      req_chan.data_byte  <= data;
      req_chan.line_level <= level;
      do @(posedge clock); while (!req_chan.ready);
      board.note_tick(op, data, level);
   endtask

   task automatic finish_op();
      while (!board.idle())
         send_tick(OP_NONE, 8'($urandom), next_level());
   endtask

   task automatic run_op(opcode_type op, logic [SHORT_WIDTH-1:0] data);
      send_tick(op, data, next_level());
      finish_op();
   endtask

   // reset pulse, then low_ticks low samples at the start of the presence window, fewer if it ends first
   task automatic reset_with_pulse(int unsigned low_ticks);
      send_tick(OP_RESET, 8'($urandom), 1'b1);
      while (board.phase == PH_RESET_LOW)
         send_tick(OP_NONE, 8'($urandom), 1'b1);
      repeat (low_ticks)
         if (!board.idle())
            send_tick(OP_NONE, 8'($urandom), 1'b0);
      while (!board.idle())
         send_tick(OP_NONE, 8'($urandom), 1'b1);
   endtask

   task automatic tick_random();
      opcode_type op;
      if (board.idle())
         op = ($urandom_range(0, 9) < 2) ? OP_NONE : opcode_type'($urandom_range(1, 3));
      else
         op = ($urandom_range(0, 7) == 0) ? opcode_type'($urandom_range(1, 3)) : OP_NONE;
      send_tick(op, 8'($urandom), next_level());
   endtask

   // bring the master to idle and wait for every outstanding result
   task automatic quiesce();
      finish_op();
      req_chan.valid <= 1'b0;
      while (board.pending() != 0)
         @(posedge clock);
   endtask

   task automatic apply_plan();
      csr_index_type idx;
      idx = idx.first();
      do begin
         csr_chan.valid <= 1'b1;
         csr_chan.index <= idx;
         csr_chan.data  <= reg_plan[idx];
         do @(posedge clock); while (!csr_chan.ready);
         board.write_reg(idx, reg_plan[idx]);
         idx = idx.next();
      end while (idx != idx.first());
      csr_chan.valid <= 1'b0;
   endtask

   task automatic fill_plan(logic [CSR_DATA_WIDTH-1:0] value);
      foreach (reg_plan[i])
         reg_plan[i] = value;
   endtask

   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (gaps_on && $urandom_range(0, 11) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready)
            board.check_tick(rsp_chan.drive_low, rsp_chan.busy_res, rsp_chan.done_res,
                             rsp_chan.status, rsp_chan.read_value);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
             || (csr_chan.valid && csr_chan.ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $error("no transaction for %0d cycles", STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   initial begin
      reset               <= 1'b1;
      req_chan.valid      <= 1'b0;
      req_chan.opcode     <= OP_NONE;
      req_chan.data_byte  <= '0;
      req_chan.line_level <= 1'b1;
      csr_chan.valid      <= 1'b0;
      csr_chan.index      <= CSR_RESET_LOW;
      csr_chan.data       <= '0;
      gaps_on             = 1'b1;
      line_stuck          = 1'b0;
      line_run_max        = 30;
      low_left            = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // register defaults out of reset
      run_op(OP_READ, 8'h00);

      // all lengths zero: one-tick phases
      fill_plan('0);
      quiesce();
      apply_plan();
      run_op(OP_WRITE, 8'h00);
      run_op(OP_WRITE, 8'hFF);
      reset_with_pulse(0);
      line_run_max = 0;
      run_op(OP_READ, 8'h5A);
      line_stuck = 1'b1;
      run_op(OP_READ, 8'hC3);
      line_stuck = 1'b0;
      // a write is started, then commands while busy are ignored
      send_tick(OP_WRITE, 8'h3C, 1'b1);
      send_tick(OP_READ, 8'hFF, 1'b0);
      send_tick(OP_RESET, 8'h81, 1'b1);
      send_tick(OP_WRITE, 8'h7E, 1'b0);
      finish_op();

      // presence thresholds
      fill_plan('0);
      reg_plan[CSR_PRESENCE_WIN] = 12'd20;
      reg_plan[CSR_PRESENCE_MIN] = 12'd15;
      quiesce();
      apply_plan();
      reset_with_pulse(0);
      reset_with_pulse(15);
      reset_with_pulse(16);
      reset_with_pulse(20);

      for (int p = 0; p < 12; p++) begin
         if (p == 3) begin
            fill_plan('0);
         end else begin
            reg_plan[CSR_RESET_LOW]    = 12'($urandom_range(0, 12));
            reg_plan[CSR_PRESENCE_WIN] = 12'($urandom_range(0, 40));
            reg_plan[CSR_ZERO_LOW]     = {4'($urandom), 8'($urandom_range(0, 8))};
            reg_plan[CSR_SHORT_LOW]    = {4'($urandom), 8'($urandom_range(0, 5))};
            reg_plan[CSR_ONE_RECOVERY] = {4'($urandom), 8'($urandom_range(0, 6))};
            reg_plan[CSR_READ_WINDOW]  = {4'($urandom), 8'($urandom_range(0, 8))};
            reg_plan[CSR_PRESENCE_MIN] = 12'($urandom_range(0, 12));
            reg_plan[CSR_READ_ONE_MAX] = {4'($urandom), 8'($urandom_range(0, 8))};
         end
         if (p >= 10)
            gaps_on = 1'b0;
         line_run_max = $urandom_range(0, 20);
         quiesce();
         apply_plan();
         repeat (45) tick_random();
      end

      quiesce();
      repeat (4) @(posedge clock);
      if (board.error_count == 0 && board.pending() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

### filelist.f
rtl/owm_pkg.sv
rtl/owm_channels.sv
rtl/onewire_bus_master_core.sv
tb/tb_onewire_bus_master_core.sv
